### design/tee_pkg.sv
// Package for the tag element extractor: widths, character codes, class and action tables.
package tee_pkg;

  localparam int unsigned MaxTagLen  = 8;
  localparam int unsigned CharW      = 8;
  localparam int unsigned NameW      = MaxTagLen * CharW;
  localparam int unsigned LenW       = 4;
  localparam int unsigned IdxW       = $clog2(MaxTagLen);
  localparam int unsigned CountW     = 16;
  localparam int unsigned StateW     = 3;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 32;

  localparam logic [NameW-1:0] NameReset = NameW'(64'd1819112552); // "html"
  localparam logic [LenW-1:0]  LenReset  = LenW'(4);

  localparam logic [CharW-1:0] ChEot   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChOpen  = 8'h3C;
  localparam logic [CharW-1:0] ChClose = 8'h3E;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;

  // Configuration register indexes.
  localparam logic CfgName = 1'b0;
  localparam logic CfgLen  = 1'b1;

  typedef logic [StateW-1:0] pstate_t;

  // Parser states that open a name comparison.
  localparam pstate_t StOpenSeen  = 3'd1;
  localparam pstate_t StCloseSeen = 3'd6;

  typedef enum logic [2:0] {
    ClsSpace  = 3'd0,
    ClsOpen   = 3'd1,
    ClsTag    = 3'd2,
    ClsClose  = 3'd3,
    ClsSlash  = 3'd4,
    ClsLetter = 3'd5
  } cls_e;

  typedef enum logic [2:0] {
    ActNone   = 3'd0,
    ActMark   = 3'd1,
    ActUnmark = 3'd2,
    ActSelect = 3'd3,
    ActPrint  = 3'd4
  } act_e;

  function automatic pstate_t next_state(input pstate_t s, input cls_e c);
    pstate_t n;
    n = s;
    case (s)
      3'd0: n = (c == ClsOpen) ? 3'd1 : 3'd0;
      3'd1: begin
        case (c)
          ClsSpace, ClsOpen: n = 3'd1;
          ClsTag:            n = 3'd2;
          default:           n = 3'd0;
        endcase
      end
      3'd2: begin
        case (c)
          ClsSpace, ClsSlash: n = 3'd3;
          ClsOpen:            n = 3'd1;
          ClsClose:           n = 3'd4;
          default:            n = 3'd0;
        endcase
      end
      3'd3: begin
        case (c)
          ClsOpen:  n = 3'd1;
          ClsClose: n = 3'd4;
          default:  n = 3'd3;
        endcase
      end
      3'd4: n = (c == ClsOpen) ? 3'd5 : 3'd4;
      3'd5: n = (c == ClsSlash) ? 3'd6 : 3'd5;
      3'd6: begin
        case (c)
          ClsSpace: n = 3'd6;
          ClsOpen:  n = 3'd5;
          ClsTag:   n = 3'd7;
          default:  n = 3'd4;
        endcase
      end
      default: begin
        case (c)
          ClsSpace: n = 3'd7;
          ClsOpen:  n = 3'd5;
          ClsClose: n = 3'd0;
          default:  n = 3'd4;
        endcase
      end
    endcase
    return n;
  endfunction

  function automatic act_e action_of(input pstate_t s, input cls_e c);
    act_e a;
    a = ActNone;
    case (s)
      3'd0, 3'd3: a = (c == ClsOpen) ? ActMark : ActNone;
      3'd1: begin
        case (c)
          ClsOpen:            a = ActMark;
          ClsSlash, ClsLetter: a = ActUnmark;
          default:            a = ActNone;
        endcase
      end
      3'd2: begin
        case (c)
          ClsOpen:           a = ActMark;
          ClsTag, ClsLetter: a = ActUnmark;
          default:           a = ActSelect;
        endcase
      end
      3'd7: a = (c == ClsClose) ? ActPrint : ActNone;
      default: a = ActNone;
    endcase
    return a;
  endfunction

endpackage

### design/tag_element_extractor.sv
// Top level of the tag element extractor: one character in, one flagged character out.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] char_in
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: char_out, in_element,
//            |     |                              |   element_done, element_discard,
//            |     |                              |   element_count, halted
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One word per cycle while the output side takes words: classification, name compare and
// the state table sit in one combinational stage between the parser registers and the
// output word register, so a result appears in the cycle after its character is taken.
// The input side stays ready while the output word is empty or is taken this cycle.
// Reset loads "html" with length 4 and clears parser, selection, count and halt.
// After an end-of-text word the parser halts; later words are still echoed.
module tag_element_extractor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // char_in [7:0]
  input  logic [tee_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // char_out [7:0], in_element [8], element_done [9], element_discard [10],
  // element_count [26:11], halted [27], zero [31:28]
  output logic [tee_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [tee_pkg::NameW-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [tee_pkg::NameW-1:0] name_q;
  logic [tee_pkg::LenW-1:0]  len_q;

  // Parser state.
  tee_pkg::pstate_t            state_q, state_d;
  logic [tee_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        sel_q, sel_d;
  logic                        cap_q, cap_d;
  logic [tee_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic                        stop_q, stop_d;

  // Output word.
  logic                        out_vld_q;
  logic [tee_pkg::CharW-1:0]   out_ch_q;
  logic                        out_inel_q, out_done_q, out_disc_q, out_halt_q;
  logic                        inel_d, done_d, disc_d, halt_d;

  logic                        in_acc;
  logic [tee_pkg::CharW-1:0]   ch;
  logic [tee_pkg::LenW-1:0]    len_eff;
  logic [tee_pkg::CharW-1:0]   name_chr;
  logic [tee_pkg::CharW-1:0]   name_first;
  logic                        cls_vld;
  tee_pkg::cls_e               cls;
  tee_pkg::act_e               act;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata[tee_pkg::CharW-1:0];

  // Clamp the name length into 1..MaxTagLen.
  always_comb begin
    if (len_q == '0) begin
      len_eff = tee_pkg::LenW'(1);
    end else if (len_q > tee_pkg::LenW'(tee_pkg::MaxTagLen)) begin
      len_eff = tee_pkg::LenW'(tee_pkg::MaxTagLen);
    end else begin
      len_eff = len_q;
    end
  end

  assign name_chr   = name_q[idx_q*tee_pkg::CharW +: tee_pkg::CharW];
  assign name_first = name_q[tee_pkg::CharW-1:0];

  // Classify the character and run one step of the table.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    cap_d   = cap_q;
    cnt_d   = cnt_q;
    stop_d  = stop_q;
    inel_d  = 1'b0;
    done_d  = 1'b0;
    disc_d  = 1'b0;
    halt_d  = 1'b1;
    cls_vld = 1'b0;
    cls     = tee_pkg::ClsLetter;
    act     = tee_pkg::ActNone;

    if (stop_q) begin
      // Halted: echo only.
      inel_d = 1'b0;
    end else if (ch == tee_pkg::ChEot) begin
      stop_d = 1'b1;
      idx_d  = '0;
      inel_d = cap_q;
    end else begin
      halt_d = 1'b0;
      if (idx_q != '0) begin
        // Inside a name comparison every character is compared raw.
        if (ch != name_chr) begin
          cls_vld = 1'b1;
          cls     = tee_pkg::ClsLetter;
          idx_d   = '0;
        end else if ({1'b0, idx_q} + tee_pkg::LenW'(1) >= len_eff) begin
          cls_vld = 1'b1;
          cls     = tee_pkg::ClsTag;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + tee_pkg::IdxW'(1);
        end
      end else if (ch == tee_pkg::ChSpace) begin
        cls_vld = 1'b1;
        cls     = tee_pkg::ClsSpace;
      end else if (ch == tee_pkg::ChOpen) begin
        cls_vld = 1'b1;
        cls     = tee_pkg::ClsOpen;
      end else if (ch == tee_pkg::ChClose) begin
        cls_vld = 1'b1;
        cls     = tee_pkg::ClsClose;
      end else if (ch == tee_pkg::ChSlash) begin
        cls_vld = 1'b1;
        cls     = tee_pkg::ClsSlash;
      end else if (state_q == tee_pkg::StOpenSeen || state_q == tee_pkg::StCloseSeen) begin
        if (ch != name_first) begin
          cls_vld = 1'b1;
          cls     = tee_pkg::ClsLetter;
        end else if (len_eff == tee_pkg::LenW'(1)) begin
          cls_vld = 1'b1;
          cls     = tee_pkg::ClsTag;
        end else begin
          idx_d = tee_pkg::IdxW'(1);
        end
      end else begin
        cls_vld = 1'b1;
        cls     = tee_pkg::ClsLetter;
      end

      if (cls_vld) begin
        act = tee_pkg::action_of(state_q, cls);
        case (act)
          tee_pkg::ActMark: cap_d = 1'b1;
          tee_pkg::ActUnmark: begin
            disc_d = cap_q;
            cap_d  = 1'b0;
          end
          tee_pkg::ActSelect: sel_d = 1'b1;
          tee_pkg::ActPrint: begin
            if (sel_q) begin
              done_d = 1'b1;
              if (cnt_q != '1) begin
                cnt_d = cnt_q + tee_pkg::CountW'(1);
              end
            end else begin
              disc_d = cap_q;
            end
            cap_d = 1'b0;
          end
          default: ;
        endcase
        state_d = tee_pkg::next_state(state_q, cls);
      end
      inel_d = cap_q || cap_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= tee_pkg::NameReset;
      len_q  <= tee_pkg::LenReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tee_pkg::CfgName: name_q <= cfg_data_i;
        tee_pkg::CfgLen:  len_q  <= cfg_data_i[tee_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Parser state: advance only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      idx_q   <= '0;
      sel_q   <= 1'b0;
      cap_q   <= 1'b0;
      cnt_q   <= '0;
      stop_q  <= 1'b0;
    end else if (in_acc) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
      cap_q   <= cap_d;
      cnt_q   <= cnt_d;
      stop_q  <= stop_d;
    end
  end

  // Output word valid: load on accept, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload: hold until the next accepted word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_ch_q   <= ch;
      out_inel_q <= inel_d;
      out_done_q <= done_d;
      out_disc_q <= disc_d;
      out_halt_q <= halt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_halt_q, cnt_q, out_disc_q, out_done_q,
                          out_inel_q, out_ch_q};

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("halt flag cleared without reset");

  a_done_disc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_done_q && out_disc_q))
    else $error("element done and discard in the same word");

  a_cnt_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (out_done_q && $past(in_acc)))
    else $error("match count moved without a completed element");

  a_idx_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (state_q == tee_pkg::StOpenSeen || state_q == tee_pkg::StCloseSeen))
    else $error("name comparison running outside a tag opening");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc) && $past(stop_q)) |-> (out_halt_q && !out_inel_q && !out_done_q))
    else $error("halted parser flagged a word");
`endif

endmodule
